[rtl/csef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csef_pkg;

	typedef logic [7:0] chan_t;

	// packed so that blue sits in the lowest byte
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	// one window column, top is the oldest line
	typedef struct packed {
		pixel_t bot;
		pixel_t mid;
		pixel_t top;
	} column_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
	} filt_ctrl_t;

	typedef logic signed [10:0] resp_t;

	localparam int unsigned NUM_RESP = 4;
	localparam int unsigned CHAN_MAX = 255;

	// Masks 4..7 of the compass set are the negations of 0..3, so only these four
	// are convolved; clamp(r) + clamp(-r) is min(|r|, CHAN_MAX).
	localparam logic signed [2:0] COMPASS_MASK [NUM_RESP][3][3] = '{
		'{'{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd2, 3'sd0, 3'sd2}, '{-3'sd1, 3'sd0, 3'sd1}},
		'{'{3'sd0, 3'sd1, 3'sd2}, '{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd2, -3'sd1, 3'sd0}},
		'{'{3'sd1, 3'sd2, 3'sd1}, '{3'sd0, 3'sd0, 3'sd0}, '{-3'sd1, -3'sd2, -3'sd1}},
		'{'{3'sd2, 3'sd1, 3'sd0}, '{3'sd1, 3'sd0, -3'sd1}, '{3'sd0, -3'sd1, -3'sd2}}
	};

endpackage

`default_nettype wire

[rtl/csef_column_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module csef_column_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                shift,
	input  csef_pkg::column_t  col_in,
	output csef_pkg::column_t  col_out
);
	import csef_pkg::*;

	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

[rtl/csef_channel_filter.sv]
`timescale 1ns / 1ps
`default_nettype none

module csef_channel_filter (
	input  wire                   clk,
	input  csef_pkg::filt_ctrl_t  ctrl,
	input  csef_pkg::chan_t       win [3][3],
	output csef_pkg::chan_t       result
);
	import csef_pkg::*;

	resp_t resp_d [NUM_RESP];
	resp_t resp_s3 [NUM_RESP];
	logic [9:0] sum_d;
	chan_t result_s4;

	always_comb begin
		for (int k = 0; k < NUM_RESP; k++) begin
			resp_d[k] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					resp_d[k] = resp_d[k] + resp_t'(signed'({3'b000, win[i][j]}))
						* resp_t'(COMPASS_MASK[k][i][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_a) begin
			resp_s3 <= resp_d;
		end
	end

	always_comb begin
		logic [10:0] mag;
		logic [7:0]  sat;
		sum_d = '0;
		for (int k = 0; k < NUM_RESP; k++) begin
			mag = resp_s3[k][10] ? 11'(-resp_s3[k]) : 11'(resp_s3[k]);
			sat = (mag > 11'(CHAN_MAX)) ? 8'(CHAN_MAX) : mag[7:0];
			sum_d = sum_d + {2'b00, sat};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_b) begin
			result_s4 <= sum_d[9:2];
		end
	end

	assign result = result_s4;

endmodule

`default_nettype wire

[rtl/compass_sobel_edge_filter.sv]
// Each output beat passes stage 1, the window chain and both filter registers. Throughput:
// one pixel per clock unless out_tready stalls the output, set by the line buffers (one read
// port used at accept, one write port used a stage later) and the three-column window
// chain feeding the filters. Border pixels give no output beat; the output register lets
// the pipeline keep filling. Reset (arst_n, async) clears counters, valid bits, window and
// sets width 640, height 480; the line buffers are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module compass_sobel_edge_filter #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	// APB configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel in
	input  wire         in_tvalid,
	output logic        in_tready,
	input  wire  [23:0] in_tdata,   // in_blue, in_green, in_red
	// result out
	output logic        out_tvalid,
	input  wire         out_tready,
	output logic [47:0] out_tdata,  // out_blue, out_green, out_red, center_row, center_col
	output logic        out_tlast   // frame_done
);
	import csef_pkg::*;

	localparam int unsigned IW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	// configuration
	logic [12:0] image_width_q, image_height_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd640;
			image_height_q <= 13'd480;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				image_height_q <= pwdata[12:0];
			end else begin
				image_width_q <= pwdata[12:0];
			end
		end
	end

	assign prdata = paddr[2] ? {19'd0, image_height_q} : {19'd0, image_width_q};

	logic [31:0] w_eff, h_eff;
	assign w_eff = (image_width_q < 13'd3) ? 32'd3 :
		((32'(image_width_q) > MAX_WIDTH) ? MAX_WIDTH : 32'(image_width_q));
	assign h_eff = (image_height_q < 13'd3) ? 32'd3 :
		((32'(image_height_q) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(image_height_q));

	// pipeline control
	logic v1_q, v2_q, v3_q, v4_q;
	logic adv1, adv2, adv3, in_acc;

	assign adv3      = v3_q & (~v4_q | out_tready);
	assign adv2      = v2_q & (~v3_q | adv3);
	assign adv1      = v1_q & (~v2_q | adv2);
	assign in_tready = ~v1_q | adv1;
	assign in_acc    = in_tvalid & in_tready;

	// position counters
	logic [IW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col, last_row, emit;

	assign last_col = 32'(col_q) >= (w_eff - 32'd1);
	assign last_row = 32'(row_q) >= (h_eff - 32'd1);
	assign emit     = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1: line buffer read and beat metadata
	pixel_t        pix_s1, rd_old_s1, rd_new_s1;
	logic [IW-1:0] idx_s1;
	logic [11:0]   crow_s1, ccol_s1;
	logic          emit_s1, done_s1;

	pixel_t mem_old [MAX_WIDTH];
	pixel_t mem_new [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_old_s1 <= mem_old[col_q];
			rd_new_s1 <= mem_new[col_q];
		end
		if (adv1) begin
			mem_old[idx_s1] <= rd_new_s1;
			mem_new[idx_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel_t'(in_tdata);
			idx_s1  <= col_q;
			crow_s1 <= 12'(32'(row_q) - 32'd1);
			ccol_s1 <= 12'(32'(col_q) - 32'd1);
			emit_s1 <= emit;
			done_s1 <= last_col & last_row;
		end
	end

	// stage 2: window chain, newest column enters on the right
	column_t col_new, col_c2, col_c1, col_c0;

	assign col_new = '{bot: pix_s1, mid: rd_new_s1, top: rd_old_s1};

	csef_column_cell u_col2 (.clk(clk), .arst_n(arst_n), .shift(adv1),
		.col_in(col_new), .col_out(col_c2));
	csef_column_cell u_col1 (.clk(clk), .arst_n(arst_n), .shift(adv1),
		.col_in(col_c2), .col_out(col_c1));
	csef_column_cell u_col0 (.clk(clk), .arst_n(arst_n), .shift(adv1),
		.col_in(col_c1), .col_out(col_c0));

	logic [11:0] crow_s2, ccol_s2, crow_s3, ccol_s3, crow_s4, ccol_s4;
	logic        done_s2, done_s3, done_s4;

	always_ff @(posedge clk) begin
		if (adv1) begin
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			done_s2 <= done_s1;
		end
		if (adv2) begin
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;
			done_s3 <= done_s2;
		end
		if (adv3) begin
			crow_s4 <= crow_s3;
			ccol_s4 <= ccol_s3;
			done_s4 <= done_s3;
		end
	end

	// stages 3 and 4: one filter per channel
	filt_ctrl_t fctrl;
	chan_t      chan_res [3];
	column_t    cols [3];

	assign fctrl.load_a = adv2;
	assign fctrl.load_b = adv3;
	assign cols[0] = col_c0;
	assign cols[1] = col_c1;
	assign cols[2] = col_c2;

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		chan_t win [3][3];
		always_comb begin
			for (int j = 0; j < 3; j++) begin
				win[0][j] = cols[j].top[8*ch +: 8];
				win[1][j] = cols[j].mid[8*ch +: 8];
				win[2][j] = cols[j].bot[8*ch +: 8];
			end
		end
		csef_channel_filter u_filt (.clk(clk), .ctrl(fctrl), .win(win),
			.result(chan_res[ch]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (in_tready) begin
				v1_q <= in_tvalid;
			end
			if (adv1) begin
				v2_q <= emit_s1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				v3_q <= 1'b1;
			end else if (adv3) begin
				v3_q <= 1'b0;
			end
			if (adv3) begin
				v4_q <= 1'b1;
			end else if (out_tready) begin
				v4_q <= 1'b0;
			end
		end
	end

	assign out_tvalid = v4_q;
	assign out_tdata  = {ccol_s4, crow_s4, chan_res[2], chan_res[1], chan_res[0]};
	assign out_tlast  = done_s4;

	// a result beat only appears after a filter stage held one
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_tvalid) |-> $past(v3_q))
		else $error("result beat without a filtered window");

	// a stalled output must not drop the beat waiting behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && out_tvalid && !out_tready |=> v3_q)
		else $error("filter stage lost a beat under stall");

	// end of row wraps the column
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_col |=> col_q == '0)
		else $error("column counter did not wrap");

	// end of frame wraps both counters
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_col && last_row |=> row_q == '0 && col_q == '0)
		else $error("frame did not restart at origin");

endmodule

`default_nettype wire
